>>> design/slc_pkg.sv
// Shared types and constants for the set-associative LRU cache model.
// No dependencies; every design file but slc_line_ram uses this package.

package slc_pkg;

   // Geometry of the line store.
   localparam int MAX_SET_BITS = 6;
   localparam int MAX_WAYS     = 8;
   localparam int STAMP_WIDTH  = 32;

   localparam int SET_W      = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
   localparam int WAY_W      = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int WCNT_W     = $clog2(MAX_WAYS + 1);
   localparam int LINE_ADDR_W = SET_W + WAY_W;
   localparam int LINE_COUNT = 2 ** LINE_ADDR_W;

   // Field widths fixed by the interface.
   localparam int ADDR_W   = 64;
   localparam int TAG_W    = 64;
   localparam int COUNT_W  = 32;
   localparam int SB_W     = 3;
   localparam int BB_W     = 5;
   localparam int WAYS_W   = 4;
   localparam int SHIFT_W  = 6;

   // Configuration port.
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   localparam csr_idx_type CSR_SET_BITS   = csr_idx_type'(0);
   localparam csr_idx_type CSR_BLOCK_BITS = csr_idx_type'(1);
   localparam csr_idx_type CSR_WAYS       = csr_idx_type'(2);

   typedef enum logic [1:0] {
      OUT_HIT   = 2'd0,
      OUT_FREE  = 2'd1,
      OUT_EVICT = 2'd2
   } outcome_type;

   typedef struct packed {
      logic [SB_W-1:0]   set_bits;
      logic [BB_W-1:0]   block_bits;
      logic [WAYS_W-1:0] ways_in_use;
   } cfg_type;

   typedef struct packed {
      logic                   valid;
      logic [TAG_W-1:0]       tag;
      logic [STAMP_WIDTH-1:0] stamp;
   } line_type;

   localparam int LINE_W = $bits(line_type);

   // Result of one pass of the way scan.
   typedef struct packed {
      logic             hit;
      logic [WAY_W-1:0] hit_way;
      logic             free;
      logic [WAY_W-1:0] free_way;
      logic [WAY_W-1:0] victim_way;
   } scan_type;

endpackage

>>> design/slc_chan_if.sv
// Request and response channel interfaces (valid/ready with payload).
// Depends on slc_pkg for the payload types.

interface slc_req_if;
   logic                       valid;
   logic                       ready;
   logic [slc_pkg::ADDR_W-1:0] address;
   logic                       mode;

   modport source (output valid, output address, output mode, input ready);
   modport sink   (input valid, input address, input mode, output ready);
endinterface

interface slc_rsp_if;
   logic                        valid;
   logic                        ready;
   slc_pkg::outcome_type        outcome;
   logic                        last_of_item;
   logic [slc_pkg::COUNT_W-1:0] hit_total;
   logic [slc_pkg::COUNT_W-1:0] miss_total;
   logic [slc_pkg::COUNT_W-1:0] eviction_total;

   modport source (output valid, output outcome, output last_of_item, output hit_total,
                   output miss_total, output eviction_total, input ready);
   modport sink   (input valid, input outcome, input last_of_item, input hit_total,
                   input miss_total, input eviction_total, output ready);
endinterface

>>> design/slc_line_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No package dependency.

module slc_line_ram #(
   parameter int ADDR_W = 9,
   parameter int DATA_W = 97
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/slc_way_scan.sv
// Shared compare unit: looks at one way per cycle while en is high and keeps
// the first hit, the first free way and the least recently used way. Uses slc_pkg.

module slc_way_scan (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            en,
   input  logic [slc_pkg::WAY_W-1:0]       way,
   input  slc_pkg::line_type               line,
   input  logic [slc_pkg::TAG_W-1:0]       tag,
   input  logic [slc_pkg::STAMP_WIDTH-1:0] stamp,
   output slc_pkg::scan_type               result
);
   import slc_pkg::*;

   logic                   hit_ff, hit_in;
   logic                   free_ff, free_in;
   logic [WAY_W-1:0]       hit_way_ff, hit_way_in;
   logic [WAY_W-1:0]       free_way_ff, free_way_in;
   logic [WAY_W-1:0]       victim_ff, victim_in;
   logic [STAMP_WIDTH-1:0] best_age_ff, best_age_in;
   logic [STAMP_WIDTH-1:0] age;
   logic                   match;

   assign age   = stamp - line.stamp;
   assign match = line.valid && (line.tag == tag);

   always_comb begin
      hit_in      = hit_ff;
      free_in     = free_ff;
      hit_way_in  = hit_way_ff;
      free_way_in = free_way_ff;
      victim_in   = victim_ff;
      best_age_in = best_age_ff;
      if (start) begin
         hit_in  = 1'b0;
         free_in = 1'b0;
      end else if (en) begin
         if (match && !hit_ff) begin
            hit_in     = 1'b1;
            hit_way_in = way;
         end
         if (!line.valid && !free_ff) begin
            free_in     = 1'b1;
            free_way_in = way;
         end
         // The first way seeds the search; ties keep the lower way.
         if ((way == '0) || (age > best_age_ff)) begin
            best_age_in = age;
            victim_in   = way;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff  <= 1'b0;
         free_ff <= 1'b0;
      end else begin
         hit_ff  <= hit_in;
         free_ff <= free_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_way_ff  <= hit_way_in;
      free_way_ff <= free_way_in;
      victim_ff   <= victim_in;
      best_age_ff <= best_age_in;
   end

   assign result.hit        = hit_ff;
   assign result.hit_way    = hit_way_ff;
   assign result.free       = free_ff;
   assign result.free_way   = free_way_ff;
   assign result.victim_way = victim_ff;

endmodule

>>> design/slc_csr.sv
// APB-style configuration registers: set bits, block bits, ways in use.
// Uses slc_pkg for the register map and the configuration struct.

module slc_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [slc_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [slc_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [slc_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready,
   output slc_pkg::cfg_type                 cfg
);
   import slc_pkg::*;

   logic [SB_W-1:0]   set_bits_ff, set_bits_in;
   logic [BB_W-1:0]   block_bits_ff, block_bits_in;
   logic [WAYS_W-1:0] ways_ff, ways_in;
   logic              wr_fire;
   csr_idx_type       idx;

   assign pready  = 1'b1;
   assign wr_fire = psel && penable && pwrite && pready;
   assign idx     = paddr[CSR_ADDR_W-1:2];

   always_comb begin
      set_bits_in   = set_bits_ff;
      block_bits_in = block_bits_ff;
      ways_in       = ways_ff;
      if (wr_fire) begin
         unique case (idx)
            CSR_SET_BITS:   set_bits_in   = pwdata[SB_W-1:0];
            CSR_BLOCK_BITS: block_bits_in = pwdata[BB_W-1:0];
            CSR_WAYS:       ways_in       = pwdata[WAYS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         CSR_SET_BITS:   prdata = CSR_DATA_W'(set_bits_ff);
         CSR_BLOCK_BITS: prdata = CSR_DATA_W'(block_bits_ff);
         CSR_WAYS:       prdata = CSR_DATA_W'(ways_ff);
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff   <= '0;
         block_bits_ff <= '0;
         ways_ff       <= WAYS_W'(1);
      end else begin
         set_bits_ff   <= set_bits_in;
         block_bits_ff <= block_bits_in;
         ways_ff       <= ways_in;
      end
   end

   assign cfg.set_bits    = set_bits_ff;
   assign cfg.block_bits  = block_bits_ff;
   assign cfg.ways_in_use = ways_ff;

endmodule

>>> design/set_assoc_lru_cache_sim.sv
// Top level of the set-associative cache with LRU replacement.
// Depends on slc_pkg, slc_chan_if, slc_line_ram, slc_way_scan and slc_csr.
//
//   Port group   Dir     Handshake          Beat content
//   req_chan     sink    valid / ready      address, mode
//   rsp_chan     source  valid / ready      outcome, last_of_item, three totals
//   csr_*        slave   APB, pready tied   set_bits, block_bits, ways_in_use
//
// Each access walks the ways of one set through a single read port, one way
// per cycle, over the effective ways in use; a load/store item makes one
// access and a modify two.
// After reset the line store is cleared one line per cycle, all LINE_COUNT
// (512) lines, during which no request beat is taken.
// A full response register only stalls the write-back step of the next access.

module set_assoc_lru_cache_sim (
   input  logic                           clock,
   input  logic                           reset,
   slc_req_if.sink                        req_chan,
   slc_rsp_if.source                      rsp_chan,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [slc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [slc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [slc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import slc_pkg::*;

   // One-hot sequencer states.
   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_SCAN  = 5'b00100,
      ST_DRAIN = 5'b01000,
      ST_WRITE = 5'b10000
   } state_type;

   state_type              state_ff, state_in;
   cfg_type                cfg;
   scan_type               scan;

   logic [LINE_ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic [SET_W-1:0]       set_ff, set_in;
   logic [TAG_W-1:0]       tag_ff, tag_in;
   logic                   modify_ff, modify_in;
   logic [WAY_W-1:0]       way_cnt_ff, way_cnt_in;
   logic [WAY_W-1:0]       rd_way_ff, rd_way_in;
   logic                   rd_vld_ff, rd_vld_in;
   logic [STAMP_WIDTH-1:0] stamp_ff, stamp_in;
   logic [COUNT_W-1:0]     hits_ff, hits_in;
   logic [COUNT_W-1:0]     misses_ff, misses_in;
   logic [COUNT_W-1:0]     evicts_ff, evicts_in;

   logic                   out_valid_ff, out_valid_in;
   outcome_type            outcome_ff, outcome_in;
   logic                   last_ff, last_in;
   logic [COUNT_W-1:0]     hit_tot_ff, hit_tot_in;
   logic [COUNT_W-1:0]     miss_tot_ff, miss_tot_in;
   logic [COUNT_W-1:0]     evict_tot_ff, evict_tot_in;

   // Effective geometry after clamping the configuration.
   logic [SB_W-1:0]        sb_eff;
   logic [WCNT_W-1:0]      ways_eff;
   logic [WAY_W-1:0]       last_way;
   logic [SHIFT_W-1:0]     tag_shift;
   logic [ADDR_W-1:0]      set_field;
   logic [SET_W-1:0]       set_mask;

   logic                   req_fire;
   logic                   scan_start;
   logic                   commit;
   logic                   mem_we;
   logic [LINE_ADDR_W-1:0] mem_waddr;
   line_type               mem_wdata;
   logic [LINE_ADDR_W-1:0] mem_raddr;
   logic [LINE_W-1:0]      mem_rdata;
   line_type               rd_line;
   outcome_type            outcome_now;
   logic [WAY_W-1:0]       target_way;

   assign sb_eff = (int'(cfg.set_bits) > MAX_SET_BITS) ? SB_W'(MAX_SET_BITS) : cfg.set_bits;

   always_comb begin
      if (cfg.ways_in_use == '0) begin
         ways_eff = WCNT_W'(1);
      end else if (int'(cfg.ways_in_use) > MAX_WAYS) begin
         ways_eff = WCNT_W'(MAX_WAYS);
      end else begin
         ways_eff = WCNT_W'(cfg.ways_in_use);
      end
   end

   assign last_way  = WAY_W'(ways_eff - WCNT_W'(1));
   assign tag_shift = SHIFT_W'(sb_eff) + SHIFT_W'(cfg.block_bits);
   assign set_field = req_chan.address >> cfg.block_bits;
   assign set_mask  = ~({SET_W{1'b1}} << sb_eff);

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;

   // Write-back needs the response register free (or being emptied).
   assign commit = (state_ff == ST_WRITE) && (!out_valid_ff || rsp_chan.ready);

   // A new access begins on an accepted request or after the first half of a modify.
   assign scan_start = req_fire || (commit && modify_ff);

   // Outcome priority: hit, then the lowest free way, then the LRU victim.
   always_comb begin
      if (scan.hit) begin
         outcome_now = OUT_HIT;
         target_way  = scan.hit_way;
      end else if (scan.free) begin
         outcome_now = OUT_FREE;
         target_way  = scan.free_way;
      end else begin
         outcome_now = OUT_EVICT;
         target_way  = scan.victim_way;
      end
   end

   // The line store is written by the clearing pass and by each write-back.
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = {set_ff, target_way};
      mem_wdata.valid = 1'b1;
      mem_wdata.tag   = tag_ff;
      mem_wdata.stamp = stamp_ff;
      if (state_ff == ST_CLEAR) begin
         mem_we          = 1'b1;
         mem_waddr       = clr_addr_ff;
         mem_wdata.valid = 1'b0;
         mem_wdata.tag   = '1;
         mem_wdata.stamp = '0;
      end else if (commit) begin
         mem_we = 1'b1;
      end
   end

   assign mem_raddr = {set_ff, way_cnt_ff};
   assign rd_line   = line_type'(mem_rdata);

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      set_in       = set_ff;
      tag_in       = tag_ff;
      modify_in    = modify_ff;
      way_cnt_in   = way_cnt_ff;
      rd_way_in    = way_cnt_ff;
      rd_vld_in    = 1'b0;
      stamp_in     = stamp_ff;
      hits_in      = hits_ff;
      misses_in    = misses_ff;
      evicts_in    = evicts_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      outcome_in   = outcome_ff;
      last_in      = last_ff;
      hit_tot_in   = hit_tot_ff;
      miss_tot_in  = miss_tot_ff;
      evict_tot_in = evict_tot_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + LINE_ADDR_W'(1);
            if (clr_addr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               // Split the address once; set and tag stay fixed for the item.
               set_in    = set_field[SET_W-1:0] & set_mask;
               tag_in    = req_chan.address >> tag_shift;
               modify_in = req_chan.mode;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            rd_vld_in  = 1'b1;
            way_cnt_in = way_cnt_ff + WAY_W'(1);
            if (way_cnt_ff == last_way) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (commit) begin
               unique case (outcome_now)
                  OUT_HIT: begin
                     hits_in = (hits_ff == '1) ? hits_ff : hits_ff + COUNT_W'(1);
                  end
                  OUT_FREE: begin
                     misses_in = (misses_ff == '1) ? misses_ff : misses_ff + COUNT_W'(1);
                  end
                  OUT_EVICT: begin
                     misses_in = (misses_ff == '1) ? misses_ff : misses_ff + COUNT_W'(1);
                     evicts_in = (evicts_ff == '1) ? evicts_ff : evicts_ff + COUNT_W'(1);
                  end
                  default: ;
               endcase
               out_valid_in = 1'b1;
               outcome_in   = outcome_now;
               last_in      = !modify_ff;
               hit_tot_in   = hits_in;
               miss_tot_in  = misses_in;
               evict_tot_in = evicts_in;
               if (modify_ff) begin
                  modify_in = 1'b0;
                  state_in  = ST_SCAN;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Every access advances the stamp before its lines are compared.
      if (scan_start) begin
         stamp_in   = stamp_ff + STAMP_WIDTH'(1);
         way_cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         modify_ff    <= 1'b0;
         way_cnt_ff   <= '0;
         rd_vld_ff    <= 1'b0;
         stamp_ff     <= '0;
         hits_ff      <= '0;
         misses_ff    <= '0;
         evicts_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         modify_ff    <= modify_in;
         way_cnt_ff   <= way_cnt_in;
         rd_vld_ff    <= rd_vld_in;
         stamp_ff     <= stamp_in;
         hits_ff      <= hits_in;
         misses_ff    <= misses_in;
         evicts_ff    <= evicts_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      set_ff       <= set_in;
      tag_ff       <= tag_in;
      rd_way_ff    <= rd_way_in;
      outcome_ff   <= outcome_in;
      last_ff      <= last_in;
      hit_tot_ff   <= hit_tot_in;
      miss_tot_ff  <= miss_tot_in;
      evict_tot_ff <= evict_tot_in;
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.outcome        = outcome_ff;
   assign rsp_chan.last_of_item   = last_ff;
   assign rsp_chan.hit_total      = hit_tot_ff;
   assign rsp_chan.miss_total     = miss_tot_ff;
   assign rsp_chan.eviction_total = evict_tot_ff;

   slc_line_ram #(
      .ADDR_W (LINE_ADDR_W),
      .DATA_W (LINE_W)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   slc_way_scan u_way_scan (
      .clock  (clock),
      .reset  (reset),
      .start  (scan_start),
      .en     (rd_vld_ff),
      .way    (rd_way_ff),
      .line   (rd_line),
      .tag    (tag_ff),
      .stamp  (stamp_ff),
      .result (scan)
   );

   slc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

endmodule

>>> verif/tb_set_assoc_lru_cache_sim.sv
`timescale 1ns / 100ps
// Self-checking testbench for set_assoc_lru_cache_sim: directed table plus random traffic.
// Depends on slc_pkg, the slc_req_if / slc_rsp_if interfaces and the cache RTL.

module tb_set_assoc_lru_cache_sim;
   import slc_pkg::*;

   // Quiet cycles allowed before the run is declared hung. The clearing pass
   // after reset and the long response hold-off both fit easily.
   localparam int unsigned QUIET_LIMIT     = 5000;
   // Length of the deliberate response hold-off used to back the block up.
   localparam int unsigned HOLD_CYCLES     = 400;
   // Wait at the end long enough for a modify at eight ways to finish, so
   // that a stray beat would still be seen.
   localparam int unsigned TAIL_CYCLES     = 50;
   localparam int unsigned PHASES          = 8;
   localparam int unsigned ITEMS_PER_PHASE = 188;
   localparam int unsigned DIRECTED_ROWS   = 24;

   typedef enum bit {
      ROW_ACCESS,
      ROW_CSR
   } row_kind_type;

   // One row of the directed table. Access rows may carry typed outcomes for
   // the first and (for a modify) second access; the totals always come from
   // the predictor.
   typedef struct packed {
      row_kind_type kind;
      csr_idx_type  csr_idx;
      logic [31:0]  csr_value;
      logic [63:0]  address;
      logic         mode;
      logic         typed;
      outcome_type  first_outcome;
      outcome_type  second_outcome;
   } stim_row_type;

   // Everything one response beat carries.
   typedef struct packed {
      outcome_type          outcome;
      logic                 last_of_item;
      logic [COUNT_W-1:0]   hit_total;
      logic [COUNT_W-1:0]   miss_total;
      logic [COUNT_W-1:0]   eviction_total;
   } access_report_type;

   logic clock;
   logic reset;

   slc_req_if req_if ();
   slc_rsp_if rsp_if ();

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   set_assoc_lru_cache_sim DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // ------------------------------------------------------------------
   // Shadow copy of the cache. Lines are laid out as in the block: each set
   // owns MAX_WAYS consecutive entries, whatever the ways in use.
   // ------------------------------------------------------------------
   logic [TAG_W-1:0]       way_tag     [LINE_COUNT];
   logic                   way_live    [LINE_COUNT];
   logic [STAMP_WIDTH-1:0] way_used_at [LINE_COUNT];
   logic [STAMP_WIDTH-1:0] use_clock;
   logic [COUNT_W-1:0]     shadow_hits;
   logic [COUNT_W-1:0]     shadow_misses;
   logic [COUNT_W-1:0]     shadow_evicts;

   // Geometry as last written over the register port.
   logic [SB_W-1:0]   geo_set_bits;
   logic [BB_W-1:0]   geo_block_bits;
   logic [WAYS_W-1:0] geo_ways;

   // Expected response beats, oldest first.
   access_report_type awaited_reports [$];

   int unsigned mismatch_count = 0;
   int unsigned quiet_cycles   = 0;

   // Idling knobs. The sender percentage is only used by the stimulus
   // process; the receiver one is changed per phase with nonblocking assignments.
   int unsigned src_idle_pct;
   int unsigned snk_stall_pct;
   int unsigned hold_requests;
   int unsigned holds_done = 0;
   int unsigned hold_left  = 0;

   int unsigned phase_set_bits   [PHASES] = '{0, 3, 6, 7, 2, 5, 1, 4};
   int unsigned phase_block_bits [PHASES] = '{0, 2, 16, 31, 0, 5, 3, 9};
   int unsigned phase_ways       [PHASES] = '{1, 4, 8, 15, 0, 9, 2, 6};
   int unsigned src_idle_by_mode [4]      = '{0, 69, 0, 31};
   int unsigned snk_stall_by_mode[4]      = '{0, 0, 69, 31};

   stim_row_type directed_rows [DIRECTED_ROWS];

   // ------------------------------------------------------------------
   // Predictor helpers.
   // ------------------------------------------------------------------

   function automatic logic [COUNT_W-1:0] sat_bump(input logic [COUNT_W-1:0] x);
      return (x == '1) ? x : x + 1'b1;
   endfunction

   // Set-bit counts above the supported maximum behave as the maximum.
   function automatic int unsigned effective_set_bits();
      return (geo_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : geo_set_bits;
   endfunction

   // Zero ways behaves as one, anything beyond MAX_WAYS as MAX_WAYS.
   function automatic int unsigned effective_ways();
      if (geo_ways == 0)
         return 1;
      return (geo_ways > MAX_WAYS) ? MAX_WAYS : geo_ways;
   endfunction

   // One cache access against the shadow state. Returns the outcome and
   // leaves the lines, the use clock and the totals updated.
   function automatic outcome_type lru_lookup(input logic [63:0] addr);
      int unsigned            sb_eff;
      int unsigned            ways_eff;
      int unsigned            base;
      int unsigned            victim;
      logic [63:0]            set_idx;
      logic [63:0]            tag;
      logic [STAMP_WIDTH-1:0] age;
      logic [STAMP_WIDTH-1:0] oldest;
      sb_eff   = effective_set_bits();
      ways_eff = effective_ways();
      set_idx  = (addr >> geo_block_bits) & ((64'd1 << sb_eff) - 64'd1);
      tag      = addr >> (sb_eff + geo_block_bits);
      base     = int'(set_idx) * MAX_WAYS;
      victim   = 0;
      oldest   = '0;
      use_clock = use_clock + 1'b1;

      // A hit needs the line to be valid as well as the tag to match, so the
      // all-ones reset tag never hits by itself.
      for (int w = 0; w < ways_eff; w++) begin
         if (way_live[base + w] && way_tag[base + w] == tag) begin
            way_used_at[base + w] = use_clock;
            shadow_hits = sat_bump(shadow_hits);
            return OUT_HIT;
         end
      end
      shadow_misses = sat_bump(shadow_misses);

      // The lowest free way is filled first.
      for (int w = 0; w < ways_eff; w++) begin
         if (!way_live[base + w]) begin
            way_live[base + w]    = 1'b1;
            way_tag[base + w]     = tag;
            way_used_at[base + w] = use_clock;
            return OUT_FREE;
         end
      end

      // Otherwise the oldest way goes; age is taken modulo the stamp width so
      // that a wrapped clock still picks the right line, lowest way on a tie.
      for (int w = 0; w < ways_eff; w++) begin
         age = use_clock - way_used_at[base + w];
         if (w == 0 || age > oldest) begin
            oldest = age;
            victim = w;
         end
      end
      shadow_evicts = sat_bump(shadow_evicts);
      way_tag[base + victim]     = tag;
      way_used_at[base + victim] = use_clock;
      return OUT_EVICT;
   endfunction

   // Queue the expected beats of one accepted item. A typed outcome from the
   // directed table replaces the predicted one, so the table is checked on
   // its own terms.
   task automatic queue_item_reports(input logic [63:0] addr, input logic mode,
                                     input logic typed, input outcome_type first_o,
                                     input outcome_type second_o);
      access_report_type r;
      r.outcome        = lru_lookup(addr);
      if (typed)
         r.outcome     = first_o;
      r.last_of_item   = !mode;
      r.hit_total      = shadow_hits;
      r.miss_total     = shadow_misses;
      r.eviction_total = shadow_evicts;
      awaited_reports.push_back(r);
      if (mode) begin
         r.outcome        = lru_lookup(addr);
         if (typed)
            r.outcome     = second_o;
         r.last_of_item   = 1'b1;
         r.hit_total      = shadow_hits;
         r.miss_total     = shadow_misses;
         r.eviction_total = shadow_evicts;
         awaited_reports.push_back(r);
      end
   endtask

   // ------------------------------------------------------------------
   // Stimulus helpers. All of them are entered and left on a rising edge.
   // ------------------------------------------------------------------

   // Offer one request beat and wait for it to be taken. Valid stays high
   // into the next item when no idle gap is drawn.
   task automatic offer_item(input logic [63:0] addr, input logic mode, input logic typed,
                             input outcome_type first_o, input outcome_type second_o);
      if ($urandom_range(99) < src_idle_pct) begin
         req_if.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < src_idle_pct);
      end
      req_if.valid   <= 1'b1;
      req_if.address <= addr;
      req_if.mode    <= mode;
      do @(posedge clock); while (!req_if.ready);
      queue_item_reports(addr, mode, typed, first_o, second_o);
   endtask

   // Stop offering and wait until every expected beat has come back, so
   // that the registers can be written while the block is idle.
   task automatic settle();
      req_if.valid <= 1'b0;
      while (awaited_reports.size() != 0)
         @(posedge clock);
   endtask

   // One register write: setup cycle, then access cycle until pready. Back
   // to back writes keep psel high; the last one of a group releases the bus.
   task automatic csr_write(input csr_idx_type idx, input logic [31:0] value,
                            input bit close_bus);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         CSR_SET_BITS:   geo_set_bits   = value[SB_W-1:0];
         CSR_BLOCK_BITS: geo_block_bits = value[BB_W-1:0];
         CSR_WAYS:       geo_ways       = value[WAYS_W-1:0];
         default: ;
      endcase
      if (close_bus) begin
         csr_psel    <= 1'b0;
         csr_penable <= 1'b0;
         csr_pwrite  <= 1'b0;
      end
   endtask

   // Random addresses under the current geometry. Most of them come from a
   // small pool of tags in the first few sets, so hits, fills and evictions
   // all happen often; the rest are raw 64-bit noise or tags near all ones.
   function automatic logic [63:0] pick_address();
      logic [63:0] noise;
      logic [63:0] tag;
      logic [63:0] set_idx;
      logic [63:0] offset;
      int unsigned sb_eff;
      int unsigned roll;
      noise  = {$urandom, $urandom};
      roll   = $urandom_range(99);
      sb_eff = effective_set_bits();
      if (roll < 12)
         return noise;
      tag = $urandom_range(effective_ways() + 3);
      if (roll < 22)
         tag = (~64'd0 >> (sb_eff + geo_block_bits)) - tag;
      set_idx = $urandom_range(3) & ((64'd1 << sb_eff) - 64'd1);
      offset  = noise & ((64'd1 << geo_block_bits) - 64'd1);
      return (tag << (sb_eff + geo_block_bits)) | (set_idx << geo_block_bits) | offset;
   endfunction

   function automatic stim_row_type acc_row(input logic [63:0] addr, input logic mode,
                                            input logic typed, input outcome_type first_o,
                                            input outcome_type second_o);
      return '{ROW_ACCESS, CSR_SET_BITS, 32'd0, addr, mode, typed, first_o, second_o};
   endfunction

   function automatic stim_row_type csr_row(input csr_idx_type idx, input logic [31:0] value);
      return '{ROW_CSR, idx, value, 64'd0, 1'b0, 1'b0, OUT_HIT, OUT_HIT};
   endfunction

   function automatic string beat_text(input access_report_type b);
      return $sformatf("outcome=%0d last=%0b hits=%0d misses=%0d evictions=%0d",
                       b.outcome, b.last_of_item, b.hit_total, b.miss_total,
                       b.eviction_total);
   endfunction

   // ------------------------------------------------------------------
   // Response side: compare each accepted beat with the oldest expectation.
   // ------------------------------------------------------------------
   task automatic check_report();
      access_report_type got;
      access_report_type want;
      got.outcome        = rsp_if.outcome;
      got.last_of_item   = rsp_if.last_of_item;
      got.hit_total      = rsp_if.hit_total;
      got.miss_total     = rsp_if.miss_total;
      got.eviction_total = rsp_if.eviction_total;
      if (awaited_reports.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("%0t: response beat with nothing expected: %s", $realtime,
                     beat_text(got));
      end else begin
         want = awaited_reports.pop_front();
         if (got.outcome !== want.outcome || got.last_of_item !== want.last_of_item ||
             got.hit_total !== want.hit_total || got.miss_total !== want.miss_total ||
             got.eviction_total !== want.eviction_total) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: mismatch, expected %s, got %s", $realtime,
                        beat_text(want), beat_text(got));
         end
      end
   endtask

   // The receiver samples at the rising edge, so it sees the values from
   // before the edge. A pending hold request keeps ready low for a long
   // stretch; otherwise ready follows the current stall percentage.
   always @(posedge clock) begin
      if (rsp_if.valid && rsp_if.ready)
         check_report();
      if (hold_left != 0) begin
         hold_left    <= hold_left - 1;
         rsp_if.ready <= 1'b0;
      end else if (holds_done != hold_requests) begin
         holds_done   <= holds_done + 1;
         hold_left    <= HOLD_CYCLES;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
   end

   // Watchdog: any accepted beat on either channel, or a register access,
   // counts as progress.
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_set_assoc_lru_cache_sim: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Main sequence.
   // ------------------------------------------------------------------
   initial begin
      stim_row_type row;
      bit           prev_was_csr;
      int unsigned  mode_sel;

      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.address <= '0;
      req_if.mode    <= 1'b0;
      csr_psel       <= 1'b0;
      csr_penable    <= 1'b0;
      csr_pwrite     <= 1'b0;
      csr_paddr      <= '0;
      csr_pwdata     <= '0;
      src_idle_pct   = 0;
      snk_stall_pct  = 0;
      hold_requests  = 0;

      // Shadow state as it stands after reset.
      for (int i = 0; i < LINE_COUNT; i++) begin
         way_tag[i]     = '1;
         way_live[i]    = 1'b0;
         way_used_at[i] = '0;
      end
      use_clock      = '0;
      shadow_hits    = '0;
      shadow_misses  = '0;
      shadow_evicts  = '0;
      geo_set_bits   = '0;
      geo_block_bits = '0;
      geo_ways       = WAYS_W'(1);

      // Directed table. The reset geometry is one set of one way, so the
      // first rows are easy to follow by hand: an all-ones address must miss
      // even though invalid lines hold an all-ones tag, and every new tag
      // after that evicts the single line.
      directed_rows = '{
         acc_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, OUT_FREE,  OUT_HIT),
         acc_row(64'h0000_0000_0000_0000, 1'b1, 1'b1, OUT_EVICT, OUT_HIT),
         acc_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, OUT_EVICT, OUT_HIT),
         acc_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, OUT_HIT,   OUT_HIT),
         // Zero ways behaves as one way; upper data bits are dropped.
         csr_row(CSR_WAYS, 32'hFFFF_FFF0),
         acc_row(64'h0000_0000_0000_0000, 1'b0, 1'b1, OUT_EVICT, OUT_HIT),
         // All ones everywhere: seven set bits act as six, 31 block bits,
         // fifteen ways act as eight. Stored lines are kept across the change.
         csr_row(CSR_SET_BITS,   32'hFFFF_FFFF),
         csr_row(CSR_BLOCK_BITS, 32'hFFFF_FFFF),
         csr_row(CSR_WAYS,       32'hFFFF_FFFF),
         acc_row(64'h0000_001F_8000_0000, 1'b1, 1'b1, OUT_FREE,  OUT_HIT),
         acc_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, OUT_FREE,  OUT_HIT),
         acc_row(64'h8000_0000_0000_0000, 1'b0, 1'b1, OUT_FREE,  OUT_HIT),
         // Four sets of sixteen-byte blocks: fill set one with eight tags,
         // then a ninth evicts the oldest and a modify of the first tag
         // evicts the next oldest before hitting.
         csr_row(CSR_SET_BITS,   32'd2),
         csr_row(CSR_BLOCK_BITS, 32'd4),
         acc_row(64'h0000_0000_0000_0050, 1'b0, 1'b0, OUT_HIT, OUT_HIT),
         acc_row(64'h0000_0000_0000_0090, 1'b0, 1'b0, OUT_HIT, OUT_HIT),
         acc_row(64'h0000_0000_0000_00D0, 1'b0, 1'b0, OUT_HIT, OUT_HIT),
         acc_row(64'h0000_0000_0000_0110, 1'b0, 1'b0, OUT_HIT, OUT_HIT),
         acc_row(64'h0000_0000_0000_0150, 1'b0, 1'b0, OUT_HIT, OUT_HIT),
         acc_row(64'h0000_0000_0000_0190, 1'b0, 1'b0, OUT_HIT, OUT_HIT),
         acc_row(64'h0000_0000_0000_01D0, 1'b0, 1'b0, OUT_HIT, OUT_HIT),
         acc_row(64'h0000_0000_0000_0210, 1'b0, 1'b0, OUT_HIT, OUT_HIT),
         acc_row(64'h0000_0000_0000_0250, 1'b0, 1'b0, OUT_HIT, OUT_HIT),
         acc_row(64'h0000_0000_0000_0050, 1'b1, 1'b0, OUT_HIT, OUT_HIT)
      };

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // The block clears its line store after reset and takes no request
      // beat meanwhile; the first offer simply waits for ready.
      prev_was_csr = 1'b0;
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         row = directed_rows[i];
         if (row.kind == ROW_CSR) begin
            if (!prev_was_csr)
               settle();
            csr_write(row.csr_idx, row.csr_value,
                      (i + 1 == DIRECTED_ROWS) || (directed_rows[i + 1].kind != ROW_CSR));
         end else begin
            offer_item(row.address, row.mode, row.typed, row.first_outcome,
                       row.second_outcome);
         end
         prev_was_csr = (row.kind == ROW_CSR);
      end

      // Random phases. Each one writes all three registers while the block
      // is idle and takes the next of the four idling patterns in turn. The first phase
      // also holds the response side off for a long stretch while requests
      // keep coming, so the block backs up and stalls its input.
      for (int phase = 0; phase < PHASES; phase++) begin
         settle();
         csr_write(CSR_SET_BITS,   phase_set_bits[phase],   1'b0);
         csr_write(CSR_BLOCK_BITS, phase_block_bits[phase], 1'b0);
         csr_write(CSR_WAYS,       phase_ways[phase],       1'b1);
         mode_sel       = phase % 4;
         src_idle_pct   = src_idle_by_mode[mode_sel];
         snk_stall_pct <= snk_stall_by_mode[mode_sel];
         if (phase == 0)
            hold_requests <= hold_requests + 1;
         repeat (ITEMS_PER_PHASE)
            offer_item(pick_address(), logic'($urandom_range(99) < 30), 1'b0,
                       OUT_HIT, OUT_HIT);
      end

      // Drain, then give any stray beat time to show up.
      settle();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && awaited_reports.size() == 0)
         $display("tb_set_assoc_lru_cache_sim: clean");
      else
         $display("tb_set_assoc_lru_cache_sim: errors");
      $finish;
   end

endmodule

>>> filelist.f
design/slc_pkg.sv
design/slc_chan_if.sv
design/slc_line_ram.sv
design/slc_way_scan.sv
design/slc_csr.sv
design/set_assoc_lru_cache_sim.sv
verif/tb_set_assoc_lru_cache_sim.sv
